>>> rtl/assert_macros.svh
// assertion macros shared by the ambient light auto brightness rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define AST_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication under synchronous active-low reset
`define AST_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/albu_pkg.sv
// package for the ambient light auto brightness unit: widths, codes, types
// no dependencies; used by the rtl modules other than albu_div through scoped names
package albu_pkg;

    localparam int P_SAMPLE_MAX = 1023;
    localparam int P_FRAC_BITS  = 16;

    localparam int RAW_W        = 16;
    localparam int LEVEL_W      = 17;
    localparam int BRIGHT_W     = 17;
    localparam int MODE_W       = 3;
    localparam int SPEED_W      = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 17;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;

    localparam int BRIDGE_MAX   = 1023;
    localparam int LOWRES_SHIFT = 6;
    localparam int SPEED_BASE   = 1000;

    // period = (speed * 16 + 1000) / 125 by reciprocal multiply
    localparam int SPEED_X_W    = 13;
    localparam int RECIP_W      = 14;
    localparam int PERIOD_RECIP = 8389;
    localparam int PERIOD_SHIFT = 20;
    localparam int PERIOD_W     = 6;

    localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CONV    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BRIDGE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOWRES  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HIGHRES = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_SPEED  = 3'd3;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CHECK    = 7'b0000010,
        S_RATIO    = 7'b0000100,
        S_APPLY    = 7'b0001000,
        S_EMA_GO   = 7'b0010000,
        S_EMA_WAIT = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic set_one;
        logic set_direct;
        logic div_start;
        logic div_ema;
        logic take_ratio;
        logic load_sb;
        logic mult;
        logic take_ema;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic auto_on;
        logic tgt_m1;
        logic tgt_zero;
        logic neg;
        logic sb_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/albu_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on assert_macros.svh
`include "assert_macros.svh"

module albu_div #(
    parameter int DW  = 33,
    parameter int DVW = 17
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [$clog2(DW+1)-1:0]  i_iters,
    input  logic [DW-1:0]            i_dividend,
    input  logic [DVW-1:0]           i_divisor,
    output logic                     o_done,
    output logic [DW-1:0]            o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DVW-1:0] r_rem, n_rem;
    logic [DW-1:0]  r_quo;
    logic [DVW-1:0] r_dvs;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW:0]   w_trial;
    logic           w_fit;

    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]} - {1'b0, r_dvs};
        w_fit   = !w_trial[DVW];
        n_rem   = w_fit ? w_trial[DVW-1:0] : {r_rem[DVW-2:0], r_quo[DW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `AST_IMPL(a_busy_count, i_clk, i_rst_n, r_busy, r_cnt != '0)

endmodule

>>> rtl/albu_dp.sv
// datapath: config registers, level decode, ratio and average arithmetic, output register
// depends on albu_pkg, albu_div and assert_macros.svh
`include "assert_macros.svh"

module albu_dp #(
    parameter int SAMPLE_MAX = albu_pkg::P_SAMPLE_MAX,
    parameter int FRAC_BITS  = albu_pkg::P_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [albu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [albu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [albu_pkg::RAW_W-1:0]          i_raw,
    input  logic                                i_read_ok,
    input  logic                                i_auto,
    input  albu_pkg::t_cmd                      i_cmd,
    output albu_pkg::t_sts                      o_sts,
    input  logic                                i_m_ready,
    output logic                                o_m_valid,
    output logic [albu_pkg::OUT_TDATA_W-1:0]    o_m_data
);

    localparam int RW   = albu_pkg::RAW_W;
    localparam int LW   = albu_pkg::LEVEL_W;
    localparam int BW   = FRAC_BITS + 1;
    localparam int EW   = BW + 7;
    localparam int DW   = LW + FRAC_BITS;
    localparam int CW   = $clog2(DW + 1);
    localparam int PW   = albu_pkg::PERIOD_W;
    localparam int XW   = albu_pkg::SPEED_X_W;
    localparam int MW   = albu_pkg::SPEED_X_W + albu_pkg::RECIP_W;
    localparam int OBW  = albu_pkg::BRIGHT_W;
    localparam int PADW = albu_pkg::OUT_TDATA_W - LW - OBW;

    localparam logic [RW-1:0] SMAX     = RW'(SAMPLE_MAX);
    localparam logic [RW-1:0] BMAX     = RW'(albu_pkg::BRIDGE_MAX);
    localparam logic [BW-1:0] FIX_ONE  = BW'(1) << FRAC_BITS;
    localparam logic [BW-1:0] FIX_LOW  = BW'((64'd1 << FRAC_BITS) / 10);
    localparam logic [DW-1:0] FIX_ONE_W = DW'(FIX_ONE);
    localparam logic [DW-1:0] FIX_LOW_W = DW'(FIX_LOW);

    logic [albu_pkg::MODE_W-1:0]  r_mode;
    logic                         r_invert;
    logic [LW-1:0]                r_target;
    logic [albu_pkg::SPEED_W-1:0] r_speed;

    logic [LW-1:0]  r_level, n_level;
    logic           r_auto;
    logic [PW-1:0]  r_period;
    logic [BW-1:0]  r_sb;
    logic [BW-1:0]  r_v;
    logic [EW-1:0]  r_prod;
    logic           r_m_valid;
    logic [albu_pkg::OUT_TDATA_W-1:0] r_m_data;

    logic [XW-1:0]  w_speed_x;
    logic [MW-1:0]  w_recip_prod;
    logic [LW-1:0]  w_lmag;
    logic [LW-1:0]  w_tmag;
    logic [DW-1:0]  w_dividend;
    logic [LW-1:0]  w_divisor;
    logic [CW-1:0]  w_iters;
    logic           w_div_done;
    logic [DW-1:0]  w_quo;
    logic [BW-1:0]  w_clamped;
    logic [BW+OBW-1:0] w_sb_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= albu_pkg::MODE_NONE;
            r_invert <= 1'b0;
            r_target <= '1;
            r_speed  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                albu_pkg::CFG_SENSOR_MODE:   r_mode   <= i_cfg_data[albu_pkg::MODE_W-1:0];
                albu_pkg::CFG_INVERT_SAMPLE: r_invert <= i_cfg_data[0];
                albu_pkg::CFG_TARGET_LEVEL:  r_target <= i_cfg_data[LW-1:0];
                albu_pkg::CFG_ADJUST_SPEED:  r_speed  <= i_cfg_data[albu_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // level decode per sensor mode
    always_comb begin
        n_level = r_level;
        case (r_mode)
            albu_pkg::MODE_CONV: begin
                if (r_invert) begin
                    n_level = (i_raw > SMAX) ? '0 : {1'b0, SMAX - i_raw};
                end else begin
                    n_level = {1'b0, i_raw};
                end
            end
            albu_pkg::MODE_BRIDGE: begin
                if (!i_read_ok) begin
                    n_level = '1;
                end else if (r_invert) begin
                    n_level = {1'b0, BMAX - i_raw};
                end else begin
                    n_level = {1'b0, i_raw};
                end
            end
            albu_pkg::MODE_LOWRES: begin
                n_level = i_read_ok ? {1'b0, i_raw >> albu_pkg::LOWRES_SHIFT} : '1;
            end
            albu_pkg::MODE_HIGHRES: begin
                n_level = i_read_ok ? {1'b0, i_raw} : '1;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_speed_x    = XW'({r_speed, 4'b0000}) + XW'(albu_pkg::SPEED_BASE);
        w_recip_prod = MW'(w_speed_x) * MW'(albu_pkg::PERIOD_RECIP);
        w_lmag       = r_level[LW-1]  ? (~r_level  + LW'(1)) : r_level;
        w_tmag       = r_target[LW-1] ? (~r_target + LW'(1)) : r_target;
        if (i_cmd.div_ema) begin
            w_dividend = DW'(r_prod) << (DW - EW);
            w_divisor  = LW'(r_period) + LW'(1);
            w_iters    = CW'(EW);
        end else begin
            w_dividend = {w_lmag, {FRAC_BITS{1'b0}}};
            w_divisor  = w_tmag;
            w_iters    = CW'(DW);
        end
        if (w_quo > FIX_ONE_W) begin
            w_clamped = FIX_ONE;
        end else if (w_quo < FIX_LOW_W) begin
            w_clamped = FIX_LOW;
        end else begin
            w_clamped = w_quo[BW-1:0];
        end
        w_sb_ext = {{OBW{1'b0}}, r_sb};
    end

    albu_div #(
        .DW  (DW),
        .DVW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_iters    (w_iters),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '1;
            r_sb    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_level <= n_level;
            end
            if (i_cmd.set_one) begin
                r_sb <= FIX_ONE;
            end else if (i_cmd.load_sb) begin
                r_sb <= r_v;
            end else if (i_cmd.take_ema) begin
                r_sb <= w_quo[BW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_auto   <= i_auto;
            r_period <= w_recip_prod[albu_pkg::PERIOD_SHIFT +: PW];
        end
        if (i_cmd.set_direct) begin
            r_v <= (r_target == '0) ? FIX_ONE : FIX_LOW;
        end else if (i_cmd.take_ratio) begin
            r_v <= w_clamped;
        end
        if (i_cmd.mult) begin
            r_prod <= EW'(r_sb) * EW'(r_period) + EW'(r_v);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_m_data <= {{PADW{1'b0}}, w_sb_ext[OBW-1:0], r_level};
        end
    end

    always_comb begin
        o_sts.auto_on  = r_auto;
        o_sts.tgt_m1   = (r_target == '1);
        o_sts.tgt_zero = (r_target == '0);
        o_sts.neg      = r_level[LW-1] ^ r_target[LW-1];
        o_sts.sb_zero  = (r_sb == '0);
        o_sts.div_done = w_div_done;
        o_sts.out_free = !r_m_valid || i_m_ready;
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

    `AST_NEXT(a_sb_stays_set, i_clk, i_rst_n, r_sb != '0, r_sb != '0)
    `AST_IMPL(a_sb_in_range, i_clk, i_rst_n, 1'b1, r_sb <= FIX_ONE)

endmodule

>>> rtl/albu_ctrl.sv
// controller state machine sequencing level decode, division and averaging
// depends on albu_pkg
module albu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  albu_pkg::t_sts i_sts,
    output albu_pkg::t_cmd o_cmd
);

    albu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= albu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            albu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = albu_pkg::S_CHECK;
                end
            end
            albu_pkg::S_CHECK: begin
                if (!i_sts.auto_on) begin
                    n_state = albu_pkg::S_DONE;
                end else if (i_sts.tgt_m1) begin
                    o_cmd.set_one = 1'b1;
                    n_state       = albu_pkg::S_DONE;
                end else if (i_sts.tgt_zero || i_sts.neg) begin
                    o_cmd.set_direct = 1'b1;
                    n_state          = albu_pkg::S_APPLY;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = albu_pkg::S_RATIO;
                end
            end
            albu_pkg::S_RATIO: begin
                if (i_sts.div_done) begin
                    o_cmd.take_ratio = 1'b1;
                    n_state          = albu_pkg::S_APPLY;
                end
            end
            albu_pkg::S_APPLY: begin
                if (i_sts.sb_zero) begin
                    o_cmd.load_sb = 1'b1;
                    n_state       = albu_pkg::S_DONE;
                end else begin
                    o_cmd.mult = 1'b1;
                    n_state    = albu_pkg::S_EMA_GO;
                end
            end
            albu_pkg::S_EMA_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_ema   = 1'b1;
                n_state         = albu_pkg::S_EMA_WAIT;
            end
            albu_pkg::S_EMA_WAIT: begin
                o_cmd.div_ema = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.take_ema = 1'b1;
                    n_state        = albu_pkg::S_DONE;
                end
            end
            albu_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = albu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = albu_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == albu_pkg::S_IDLE);

endmodule

>>> rtl/ambient_light_auto_brightness_unit.sv
// Ambient light auto brightness unit: one reading in, one light level and smoothed
// brightness out per transfer. The shared bit-serial divider forms FRAC_BITS+17
// quotient bits for level/target and FRAC_BITS+8 for the average. Auto brightness off
// or a target of -1 needs no division; a target of 0, or a level and target of opposite
// sign, skips the ratio division, and the first value skips the average division.
// A finished result waits in the output register while the next reading is taken.
// Configuration is accepted every cycle and must only be written idle.
// depends on albu_pkg, albu_ctrl, albu_dp and assert_macros.svh
`include "assert_macros.svh"

module ambient_light_auto_brightness_unit #(
    parameter int SAMPLE_MAX = albu_pkg::P_SAMPLE_MAX,
    parameter int FRAC_BITS  = albu_pkg::P_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] raw_word, [16] auto_enabled, [23:17] zero
    input  logic [albu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] read_ok
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [16:0] level, [33:17] brightness, [39:34] zero
    output logic [albu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [albu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [albu_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    albu_pkg::t_cmd w_cmd;
    albu_pkg::t_sts w_sts;
    logic           w_in_ready;

    albu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    albu_dp #(
        .SAMPLE_MAX (SAMPLE_MAX),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_raw       (s_axis_tdata[albu_pkg::RAW_W-1:0]),
        .i_read_ok   (s_axis_tuser),
        .i_auto      (s_axis_tdata[albu_pkg::RAW_W]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata)
    );

    assign s_axis_tready = w_in_ready;
    assign o_cfg_ready   = 1'b1;

    `AST_NEXT(a_busy_after_transfer, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
